>>> src/fla_pkg.sv
// Shared types and constants of the free list allocator.
// Used by the datapath, controller and top level; no dependencies.
`default_nettype none

package fla_pkg;

	localparam int ADDR_BITS  = 20;
	localparam int ALIGN_W    = 13;
	localparam int PAD_W      = 12;
	localparam int MAX_ALIGN  = 4096;
	localparam int POOL_RESET = 65536;

	typedef enum logic [1:0] {
		MODE_ALLOC = 2'd0,
		MODE_FREE  = 2'd1,
		MODE_POOL  = 2'd2,
		MODE_NOP   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		STAT_OK      = 3'd0,
		STAT_NOFIT   = 3'd1,
		STAT_ZERO    = 3'd2,
		STAT_UNKNOWN = 3'd3,
		STAT_FULL    = 3'd4
	} status_t;

	typedef enum logic [0:0] {
		REG_POOL_BYTES  = 1'b0,
		REG_SEARCH_MODE = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0] start;
		logic [ADDR_BITS-1:0] length;
	} free_ent_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0] user;
		logic [ADDR_BITS-1:0] span;
		logic [PAD_W-1:0]     pad;
	} alloc_ent_t;

	typedef enum logic [4:0] {
		CMD_NONE, CMD_LATCH, CMD_POOL_INIT, CMD_POOL_RESET, CMD_SET_STATUS,
		CMD_SLOT_NEXT, CMD_SCAN_BEGIN, CMD_FREE_RD, CMD_DIV_START, CMD_PAD,
		CMD_NEED, CMD_CMP, CMD_REMAIN, CMD_CARVE, CMD_UP_RD, CMD_UP_WR,
		CMD_UP_END, CMD_ALLOC_REC, CMD_LOOK_RD, CMD_LOOK_HIT, CMD_POS_STEP,
		CMD_POS_NEXT, CMD_JOIN, CMD_MERGE_LEN, CMD_WR_PREV, CMD_WR_POS,
		CMD_DN_BEGIN, CMD_DN_RD, CMD_DN_WR, CMD_INS_END, CMD_FREE_DONE
	} dp_cmd_t;

	typedef struct packed {
		dp_cmd_t op;
		status_t code;
	} dp_ctl_t;

	typedef struct packed {
		mode_t mode;
		logic  size_zero;
		logic  slot_free;
		logic  slot_last;
		logic  idx_end;
		logic  found;
		logic  rem_busy;
		logic  fits;
		logic  exact;
		logic  split_ok;
		logic  up_more;
		logic  user_match;
		logic  start_below;
		logic  join_next;
		logic  join_prev;
		logic  table_full;
		logic  dn_more;
	} dp_status_t;

	typedef enum logic [4:0] {
		S_INIT, S_IDLE, S_DISPATCH, S_A_SLOT, S_A_RD, S_A_DIVGO, S_A_DIV,
		S_A_NEED, S_A_CMP, S_A_REMAIN, S_A_CARVE, S_UP_RD, S_UP_WR, S_A_REC,
		S_F_LOOK, S_F_CHK, S_F_POS_RD, S_F_POS_CHK, S_F_JOIN, S_F_ACT, S_F_WR,
		S_DN_RD, S_DN_WR, S_F_DONE, S_RESP
	} ctrl_state_t;

endpackage

`default_nettype wire

>>> src/fla_rem_unit.sv
// Bit-serial restoring remainder unit, one quotient bit per cycle.
// Depends on nothing but its ports.
`default_nettype none

module fla_rem_unit #(
	parameter int DW = 21,
	parameter int VW = 13
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] dividend,
	input  wire logic [VW-1:0] divisor,
	output logic               busy,
	output logic [VW-1:0]      remainder
);

	localparam int CNT_W = $clog2(DW + 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DW-1:0]    num_q;
	logic [VW-1:0]    rem_q;
	logic [VW-1:0]    div_q;
	logic [VW:0]      trial;
	logic [VW:0]      diff;

	assign trial = {rem_q, num_q[DW-1]};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[DW-2:0], 1'b0};
			if (trial >= {1'b0, div_q}) begin
				rem_q <= diff[VW-1:0];
			end else begin
				rem_q <= trial[VW-1:0];
			end
		end
	end

	assign busy      = busy_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

>>> src/fla_datapath.sv
// Datapath of the free list allocator: free table and allocation memories, scan registers.
// Depends on fla_pkg and fla_rem_unit; driven by commands from fla_ctrl.
`default_nettype none

module fla_datapath
	import fla_pkg::*;
#(
	parameter int FREE_ENTRIES    = 64,
	parameter int ALLOC_ENTRIES   = 64,
	parameter int HEADER_BYTES    = 16,
	parameter int FREEBLOCK_BYTES = 16,
	parameter int DEFAULT_ALIGN   = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire dp_ctl_t              ctl,
	input  wire mode_t                in_mode,
	input  wire logic [ADDR_BITS-1:0] in_request_bytes,
	input  wire logic [ALIGN_W-1:0]   in_alignment,
	input  wire logic [ADDR_BITS-1:0] in_user_offset,
	input  wire logic [ADDR_BITS-1:0] pool_bytes,
	output dp_status_t                st,
	output status_t                   res_status,
	output logic [ADDR_BITS-1:0]      res_offset,
	output logic [PAD_W-1:0]          res_padding
);

	localparam int A   = ADDR_BITS;
	localparam int WW  = ADDR_BITS + 2;
	localparam int FIW = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
	localparam int FCW = $clog2(FREE_ENTRIES + 1);
	localparam int AIW = (ALLOC_ENTRIES > 1) ? $clog2(ALLOC_ENTRIES) : 1;

	free_ent_t  free_mem [FREE_ENTRIES];
	alloc_ent_t alloc_mem [ALLOC_ENTRIES];

	free_ent_t  rd_q;
	alloc_ent_t a_rd_q;
	free_ent_t  cur_q;
	free_ent_t  prev_q;
	free_ent_t  next_q;

	mode_t              mode_q;
	logic [A-1:0]       size_q;
	logic [ALIGN_W-1:0] al_q;
	logic [A-1:0]       uoff_q;

	logic [FCW-1:0] cnt_q;
	logic [FCW-1:0] idx_q;
	logic [FCW-1:0] pos_q;
	logic [FCW-1:0] pick_q;
	logic [AIW-1:0] aidx_q;
	logic [ALLOC_ENTRIES-1:0] valid_q;

	logic [PAD_W-1:0] pad_q;
	logic [WW-1:0]    need_q;
	logic [WW-1:0]    tot_q;
	logic             found_q;
	logic [WW-1:0]    best_waste_q;
	logic [WW-1:0]    best_need_q;
	logic [PAD_W-1:0] best_pad_q;
	logic [A-1:0]     best_start_q;
	logic [WW-1:0]    best_tot_q;
	logic [WW-1:0]    remain_q;
	logic [A-1:0]     span_q;
	logic [A-1:0]     s_q;
	logic [WW-1:0]    len_q;
	logic             has_next_q;
	logic             jn_q;
	logic             jp_q;

	status_t      res_status_q;
	logic [A-1:0] res_off_q;
	logic [PAD_W-1:0] res_pad_q;

	logic               rem_start;
	logic               rem_busy;
	logic [ALIGN_W-1:0] rem_val;
	logic [A:0]         rem_dividend;

	logic [FCW-1:0]   idx_p1;
	logic [FCW-1:0]   idx_m1;
	logic [FCW-1:0]   pos_m1;
	logic [FIW-1:0]   raddr;
	logic             fw_en;
	logic [FIW-1:0]   fw_addr;
	free_ent_t        fw_data;
	logic             aw_en;
	alloc_ent_t       aw_data;
	logic [WW-1:0]    waste_c;
	logic             fits_c;
	logic [ALIGN_W-1:0] split_al;
	logic [WW-1:0]    pool_w;
	logic [WW-1:0]    init_len;
	logic [A-1:0]     user_c;
	logic [WW-1:0]    span_w;
	logic [A-1:0]     s_c;

	assign idx_p1 = idx_q + 1'b1;
	assign idx_m1 = idx_q - 1'b1;
	assign pos_m1 = pos_q - 1'b1;

	assign rem_start    = (ctl.op == CMD_DIV_START);
	assign rem_dividend = {1'b0, rd_q.start} + (A + 1)'(HEADER_BYTES);

	fla_rem_unit #(
		.DW(A + 1),
		.VW(ALIGN_W)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (rem_dividend),
		.divisor  (al_q),
		.busy     (rem_busy),
		.remainder(rem_val)
	);

	assign waste_c  = tot_q - need_q;
	assign fits_c   = (tot_q >= need_q) && (!found_q || (waste_c < best_waste_q));
	assign split_al = (al_q > ALIGN_W'(FREEBLOCK_BYTES)) ? al_q : ALIGN_W'(FREEBLOCK_BYTES);
	assign pool_w   = (ctl.op == CMD_POOL_INIT) ? WW'(POOL_RESET) : WW'(pool_bytes);
	assign init_len = (pool_w >= WW'(FREEBLOCK_BYTES)) ? pool_w - WW'(FREEBLOCK_BYTES) : '0;
	assign user_c   = best_start_q + A'(best_pad_q) + A'(HEADER_BYTES);
	assign span_w   = WW'(a_rd_q.span);
	assign s_c      = uoff_q - A'(HEADER_BYTES) - A'(a_rd_q.pad);

	always_comb begin
		case (ctl.op)
			CMD_UP_RD: raddr = idx_p1[FIW-1:0];
			CMD_DN_RD: raddr = idx_m1[FIW-1:0];
			default:   raddr = idx_q[FIW-1:0];
		endcase
	end

	always_comb begin
		fw_en   = 1'b0;
		fw_addr = idx_q[FIW-1:0];
		fw_data = rd_q;
		case (ctl.op)
			CMD_POOL_INIT, CMD_POOL_RESET: begin
				fw_en   = 1'b1;
				fw_addr = '0;
				fw_data = '{start: '0, length: init_len[A-1:0]};
			end
			CMD_CARVE: begin
				fw_en   = (remain_q >= WW'(FREEBLOCK_BYTES) + WW'(split_al));
				fw_addr = pick_q[FIW-1:0];
				fw_data.start  = best_start_q + best_need_q[A-1:0];
				fw_data.length = remain_q[A-1:0] - A'(FREEBLOCK_BYTES);
			end
			CMD_UP_WR, CMD_DN_WR: begin
				fw_en = 1'b1;
			end
			CMD_WR_PREV: begin
				fw_en   = 1'b1;
				fw_addr = pos_m1[FIW-1:0];
				fw_data.start  = prev_q.start;
				fw_data.length = prev_q.length + len_q[A-1:0] + A'(FREEBLOCK_BYTES);
			end
			CMD_WR_POS, CMD_INS_END: begin
				fw_en   = 1'b1;
				fw_addr = pos_q[FIW-1:0];
				fw_data = '{start: s_q, length: len_q[A-1:0]};
			end
			default: begin
				fw_en = 1'b0;
			end
		endcase
	end

	assign aw_en   = (ctl.op == CMD_ALLOC_REC);
	assign aw_data = '{user: user_c, span: span_q, pad: best_pad_q};

	always_ff @(posedge clk) begin
		if (fw_en) begin
			free_mem[fw_addr] <= fw_data;
		end
		rd_q <= free_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (aw_en) begin
			alloc_mem[aidx_q] <= aw_data;
		end
		a_rd_q <= alloc_mem[aidx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			idx_q      <= '0;
			pos_q      <= '0;
			pick_q     <= '0;
			aidx_q     <= '0;
			valid_q    <= '0;
			found_q    <= 1'b0;
			has_next_q <= 1'b0;
			jn_q       <= 1'b0;
			jp_q       <= 1'b0;
			mode_q     <= MODE_NOP;
			res_status_q <= STAT_OK;
		end else begin
			case (ctl.op)
				CMD_LATCH: begin
					mode_q       <= in_mode;
					idx_q        <= '0;
					aidx_q       <= '0;
					found_q      <= 1'b0;
					res_status_q <= STAT_OK;
				end
				CMD_POOL_INIT, CMD_POOL_RESET: begin
					cnt_q   <= (pool_w >= WW'(FREEBLOCK_BYTES)) ? FCW'(1) : '0;
					valid_q <= '0;
				end
				CMD_SET_STATUS: res_status_q <= ctl.code;
				CMD_SLOT_NEXT:  aidx_q <= aidx_q + 1'b1;
				CMD_SCAN_BEGIN: idx_q <= '0;
				CMD_CMP: begin
					idx_q <= idx_p1;
					if (fits_c) begin
						found_q <= 1'b1;
						pick_q  <= idx_q;
					end
				end
				CMD_CARVE:  idx_q <= pick_q;
				CMD_UP_WR:  idx_q <= idx_p1;
				CMD_UP_END: cnt_q <= cnt_q - 1'b1;
				CMD_ALLOC_REC: valid_q[aidx_q] <= 1'b1;
				CMD_LOOK_HIT: begin
					idx_q      <= '0;
					has_next_q <= 1'b0;
				end
				CMD_POS_STEP: idx_q <= idx_p1;
				CMD_POS_NEXT: has_next_q <= 1'b1;
				CMD_JOIN: begin
					pos_q <= idx_q;
					jn_q  <= has_next_q && (WW'(next_q.start) == WW'(s_q) + WW'(span_q));
					jp_q  <= (idx_q != '0) && (WW'(prev_q.start) + WW'(prev_q.length)
						+ WW'(FREEBLOCK_BYTES) == WW'(s_q));
				end
				CMD_WR_PREV:   idx_q <= pos_q;
				CMD_DN_BEGIN:  idx_q <= cnt_q;
				CMD_DN_WR:     idx_q <= idx_m1;
				CMD_INS_END:   cnt_q <= cnt_q + 1'b1;
				CMD_FREE_DONE: valid_q[aidx_q] <= 1'b0;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			CMD_LATCH: begin
				size_q    <= in_request_bytes;
				uoff_q    <= in_user_offset;
				res_off_q <= '0;
				res_pad_q <= '0;
				if (in_alignment == '0) begin
					al_q <= ALIGN_W'(DEFAULT_ALIGN);
				end else if (in_alignment > ALIGN_W'(MAX_ALIGN)) begin
					al_q <= ALIGN_W'(MAX_ALIGN);
				end else begin
					al_q <= in_alignment;
				end
			end
			CMD_DIV_START: cur_q <= rd_q;
			CMD_PAD: begin
				if (rem_val == '0) begin
					pad_q <= '0;
				end else begin
					pad_q <= PAD_W'(al_q - rem_val);
				end
			end
			CMD_NEED: begin
				need_q <= WW'(pad_q) + WW'(HEADER_BYTES) + WW'(size_q);
				tot_q  <= WW'(cur_q.length) + WW'(FREEBLOCK_BYTES);
			end
			CMD_CMP: begin
				if (fits_c) begin
					best_waste_q <= waste_c;
					best_need_q  <= need_q;
					best_pad_q   <= pad_q;
					best_start_q <= cur_q.start;
					best_tot_q   <= tot_q;
				end
			end
			CMD_REMAIN: remain_q <= best_tot_q - best_need_q;
			CMD_CARVE: begin
				if (remain_q >= WW'(FREEBLOCK_BYTES) + WW'(split_al)) begin
					span_q <= best_need_q[A-1:0];
				end else begin
					span_q <= best_tot_q[A-1:0];
				end
			end
			CMD_ALLOC_REC: begin
				res_off_q <= user_c;
				res_pad_q <= best_pad_q;
			end
			CMD_LOOK_HIT: begin
				span_q <= a_rd_q.span;
				s_q    <= s_c;
				if (span_w >= WW'(FREEBLOCK_BYTES)) begin
					len_q <= span_w - WW'(FREEBLOCK_BYTES);
				end else begin
					len_q <= '0;
				end
			end
			CMD_POS_STEP: prev_q <= rd_q;
			CMD_POS_NEXT: next_q <= rd_q;
			CMD_MERGE_LEN: begin
				if (jn_q) begin
					len_q <= len_q + WW'(next_q.length) + WW'(FREEBLOCK_BYTES);
				end
			end
			default: begin
			end
		endcase
	end

	assign st.mode        = mode_q;
	assign st.size_zero   = (size_q == '0);
	assign st.slot_free   = !valid_q[aidx_q];
	assign st.slot_last   = (aidx_q == AIW'(ALLOC_ENTRIES - 1));
	assign st.idx_end     = (idx_q == cnt_q);
	assign st.found       = found_q;
	assign st.rem_busy    = rem_busy;
	assign st.fits        = fits_c;
	assign st.exact       = (tot_q == need_q);
	assign st.split_ok    = (remain_q >= WW'(FREEBLOCK_BYTES) + WW'(split_al));
	assign st.up_more     = ({1'b0, idx_q} + 1'b1) < {1'b0, cnt_q};
	assign st.user_match  = (a_rd_q.user == uoff_q);
	assign st.start_below = (rd_q.start < s_q);
	assign st.join_next   = jn_q;
	assign st.join_prev   = jp_q;
	assign st.table_full  = (cnt_q >= FCW'(FREE_ENTRIES));
	assign st.dn_more     = (idx_q > pos_q);

	assign res_status  = res_status_q;
	assign res_offset  = res_off_q;
	assign res_padding = res_pad_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FCW'(FREE_ENTRIES))
		else $error("free count exceeds table depth");

	a_ins_room: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == CMD_INS_END) |-> (cnt_q < FCW'(FREE_ENTRIES)))
		else $error("insert into a full free table");

	a_remove_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == CMD_UP_END) |-> (cnt_q != '0))
		else $error("entry removed from an empty free table");

	a_rec_found: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == CMD_ALLOC_REC) |-> (found_q && !valid_q[aidx_q]))
		else $error("allocation recorded without a fit or into a live slot");

endmodule

`default_nettype wire

>>> src/fla_ctrl.sv
// Controller state machine of the free list allocator.
// Depends on fla_pkg; sequences fla_datapath through command and status structs.
`default_nettype none

module fla_ctrl
	import fla_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       search_mode,
	input  wire logic       out_free,
	output logic            resp_load,
	input  wire dp_status_t st,
	output dp_ctl_t         ctl
);

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_INIT: state_d = S_IDLE;
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (st.mode)
					MODE_ALLOC: state_d = st.size_zero ? S_RESP : S_A_SLOT;
					MODE_FREE:  state_d = S_F_LOOK;
					default:    state_d = S_RESP;
				endcase
			end
			S_A_SLOT: begin
				if (st.slot_free) begin
					state_d = S_A_RD;
				end else if (st.slot_last) begin
					state_d = S_RESP;
				end
			end
			S_A_RD: begin
				if (!st.idx_end) begin
					state_d = S_A_DIVGO;
				end else if (st.found) begin
					state_d = S_A_REMAIN;
				end else begin
					state_d = S_RESP;
				end
			end
			S_A_DIVGO: state_d = S_A_DIV;
			S_A_DIV: begin
				if (!st.rem_busy) begin
					state_d = S_A_NEED;
				end
			end
			S_A_NEED: state_d = S_A_CMP;
			S_A_CMP: begin
				if (st.fits && (!search_mode || st.exact)) begin
					state_d = S_A_REMAIN;
				end else begin
					state_d = S_A_RD;
				end
			end
			S_A_REMAIN: state_d = S_A_CARVE;
			S_A_CARVE:  state_d = st.split_ok ? S_A_REC : S_UP_RD;
			S_UP_RD: begin
				if (st.up_more) begin
					state_d = S_UP_WR;
				end else if (st.mode == MODE_ALLOC) begin
					state_d = S_A_REC;
				end else begin
					state_d = S_F_DONE;
				end
			end
			S_UP_WR: state_d = S_UP_RD;
			S_A_REC: state_d = S_RESP;
			S_F_LOOK: begin
				if (!st.slot_free) begin
					state_d = S_F_CHK;
				end else if (st.slot_last) begin
					state_d = S_RESP;
				end
			end
			S_F_CHK: begin
				if (st.user_match) begin
					state_d = S_F_POS_RD;
				end else if (st.slot_last) begin
					state_d = S_RESP;
				end else begin
					state_d = S_F_LOOK;
				end
			end
			S_F_POS_RD:  state_d = st.idx_end ? S_F_JOIN : S_F_POS_CHK;
			S_F_POS_CHK: state_d = st.start_below ? S_F_POS_RD : S_F_JOIN;
			S_F_JOIN:    state_d = S_F_ACT;
			S_F_ACT: begin
				if (!st.join_next && !st.join_prev && st.table_full) begin
					state_d = S_RESP;
				end else begin
					state_d = S_F_WR;
				end
			end
			S_F_WR: begin
				if (st.join_prev) begin
					state_d = st.join_next ? S_UP_RD : S_F_DONE;
				end else if (st.join_next) begin
					state_d = S_F_DONE;
				end else begin
					state_d = S_DN_RD;
				end
			end
			S_DN_RD:  state_d = st.dn_more ? S_DN_WR : S_F_DONE;
			S_DN_WR:  state_d = S_DN_RD;
			S_F_DONE: state_d = S_RESP;
			S_RESP: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_INIT;
		endcase
	end

	always_comb begin
		ctl.op    = CMD_NONE;
		ctl.code  = STAT_OK;
		in_ready  = 1'b0;
		resp_load = 1'b0;
		case (state_q)
			S_INIT: ctl.op = CMD_POOL_INIT;
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.op = CMD_LATCH;
				end
			end
			S_DISPATCH: begin
				case (st.mode)
					MODE_ALLOC: begin
						if (st.size_zero) begin
							ctl.op   = CMD_SET_STATUS;
							ctl.code = STAT_ZERO;
						end
					end
					MODE_POOL: ctl.op = CMD_POOL_RESET;
					default:   ctl.op = CMD_NONE;
				endcase
			end
			S_A_SLOT: begin
				if (st.slot_free) begin
					ctl.op = CMD_SCAN_BEGIN;
				end else if (st.slot_last) begin
					ctl.op   = CMD_SET_STATUS;
					ctl.code = STAT_FULL;
				end else begin
					ctl.op = CMD_SLOT_NEXT;
				end
			end
			S_A_RD: begin
				if (!st.idx_end) begin
					ctl.op = CMD_FREE_RD;
				end else if (!st.found) begin
					ctl.op   = CMD_SET_STATUS;
					ctl.code = STAT_NOFIT;
				end
			end
			S_A_DIVGO: ctl.op = CMD_DIV_START;
			S_A_DIV: begin
				if (!st.rem_busy) begin
					ctl.op = CMD_PAD;
				end
			end
			S_A_NEED:   ctl.op = CMD_NEED;
			S_A_CMP:    ctl.op = CMD_CMP;
			S_A_REMAIN: ctl.op = CMD_REMAIN;
			S_A_CARVE:  ctl.op = CMD_CARVE;
			S_UP_RD:    ctl.op = st.up_more ? CMD_UP_RD : CMD_UP_END;
			S_UP_WR:    ctl.op = CMD_UP_WR;
			S_A_REC:    ctl.op = CMD_ALLOC_REC;
			S_F_LOOK: begin
				if (!st.slot_free) begin
					ctl.op = CMD_LOOK_RD;
				end else if (st.slot_last) begin
					ctl.op   = CMD_SET_STATUS;
					ctl.code = STAT_UNKNOWN;
				end else begin
					ctl.op = CMD_SLOT_NEXT;
				end
			end
			S_F_CHK: begin
				if (st.user_match) begin
					ctl.op = CMD_LOOK_HIT;
				end else if (st.slot_last) begin
					ctl.op   = CMD_SET_STATUS;
					ctl.code = STAT_UNKNOWN;
				end else begin
					ctl.op = CMD_SLOT_NEXT;
				end
			end
			S_F_POS_RD: begin
				if (!st.idx_end) begin
					ctl.op = CMD_FREE_RD;
				end
			end
			S_F_POS_CHK: ctl.op = st.start_below ? CMD_POS_STEP : CMD_POS_NEXT;
			S_F_JOIN:    ctl.op = CMD_JOIN;
			S_F_ACT: begin
				if (!st.join_next && !st.join_prev && st.table_full) begin
					ctl.op   = CMD_SET_STATUS;
					ctl.code = STAT_FULL;
				end else begin
					ctl.op = CMD_MERGE_LEN;
				end
			end
			S_F_WR: begin
				if (st.join_prev) begin
					ctl.op = CMD_WR_PREV;
				end else if (st.join_next) begin
					ctl.op = CMD_WR_POS;
				end else begin
					ctl.op = CMD_DN_BEGIN;
				end
			end
			S_DN_RD:  ctl.op = st.dn_more ? CMD_DN_RD : CMD_INS_END;
			S_DN_WR:  ctl.op = CMD_DN_WR;
			S_F_DONE: ctl.op = CMD_FREE_DONE;
			S_RESP:   resp_load = out_free;
			default:  ctl.op = CMD_NONE;
		endcase
	end

	a_resp_room: assert property (@(posedge clk) disable iff (!arst_n)
		resp_load |-> out_free)
		else $error("result loaded while the output register is occupied");

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == CMD_LATCH) |=> (state_q == S_DISPATCH))
		else $error("accepted request not dispatched");

	a_resp_return: assert property (@(posedge clk) disable iff (!arst_n)
		resp_load |=> (state_q == S_IDLE))
		else $error("controller did not return to idle after a result");

endmodule

`default_nettype wire

>>> src/free_list_allocator_unit.sv
// Top level of the free list allocator: stream ports, register port, output register.
// Depends on fla_pkg, fla_ctrl and fla_datapath.
//
//   Channel  Direction  Handshake          Payload
//   s_*      in         s_tvalid/s_tready  s_tuser mode, s_tdata request fields
//   m_*      out        m_tvalid/m_tready  m_tdata status, offset, padding
//   cfg_*    in         cfg_valid/cfg_ready cfg_index register, cfg_data value
//
// One request is in work at a time; s_tready is high only while the controller is idle.
// Allocate: a scan of up to ALLOC_ENTRIES slots, then for each free entry tried a run of
// the bit-serial alignment remainder unit, plus a shift of the table entries behind one
// removed. Free: a search of the slots, a walk of the free entries and a shift of entries
// on insertion. Reset builds the table with a single entry.
// A pending result in the output register stalls only the next completion.
`default_nettype none

module free_list_allocator_unit
	import fla_pkg::*;
#(
	parameter int FREE_ENTRIES    = 64,
	parameter int ALLOC_ENTRIES   = 64,
	parameter int HEADER_BYTES    = 16,
	parameter int FREEBLOCK_BYTES = 16,
	parameter int DEFAULT_ALIGN   = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [55:0] s_tdata,  // request_bytes[19:0], alignment[32:20], user_offset[52:33]
	input  wire logic [1:0]  s_tuser,  // mode[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,  // status[2:0], result_offset[22:3], padding_bytes[34:23]
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [19:0] cfg_data
);

	logic [ADDR_BITS-1:0] pool_bytes_q;
	logic                 search_mode_q;
	logic                 out_valid_q;
	status_t              out_status_q;
	logic [ADDR_BITS-1:0] out_offset_q;
	logic [PAD_W-1:0]     out_pad_q;

	logic                 out_free;
	logic                 resp_load;
	dp_ctl_t              ctl;
	dp_status_t           st;
	status_t              res_status;
	logic [ADDR_BITS-1:0] res_offset;
	logic [PAD_W-1:0]     res_padding;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_bytes_q  <= ADDR_BITS'(POOL_RESET);
			search_mode_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_POOL_BYTES:  pool_bytes_q  <= cfg_data;
				REG_SEARCH_MODE: search_mode_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign out_free = !out_valid_q || m_tready;

	fla_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.search_mode(search_mode_q),
		.out_free   (out_free),
		.resp_load  (resp_load),
		.st         (st),
		.ctl        (ctl)
	);

	fla_datapath #(
		.FREE_ENTRIES   (FREE_ENTRIES),
		.ALLOC_ENTRIES  (ALLOC_ENTRIES),
		.HEADER_BYTES   (HEADER_BYTES),
		.FREEBLOCK_BYTES(FREEBLOCK_BYTES),
		.DEFAULT_ALIGN  (DEFAULT_ALIGN)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.in_mode         (mode_t'(s_tuser)),
		.in_request_bytes(s_tdata[19:0]),
		.in_alignment    (s_tdata[32:20]),
		.in_user_offset  (s_tdata[52:33]),
		.pool_bytes      (pool_bytes_q),
		.st              (st),
		.res_status      (res_status),
		.res_offset      (res_offset),
		.res_padding     (res_padding)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (resp_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (resp_load) begin
			out_status_q <= res_status;
			out_offset_q <= res_offset;
			out_pad_q    <= res_padding;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_pad_q, out_offset_q, out_status_q};

endmodule

`default_nettype wire

>>> verif/tb_free_list_allocator_unit.sv
// Testbench for free_list_allocator_unit: random and directed allocate, free and pool reset
// requests, checked beat by beat against a predictor of the block. Needs fla_pkg and the RTL.
`timescale 1ns / 100ps

typedef struct {
	fla_pkg::status_t status;
	logic [19:0]      offset;
	logic [11:0]      pad;
} alloc_reply_t;

class alloc_scoreboard;
	longint unsigned pool_sz;
	bit              search_best;
	longint unsigned fstart[64];
	longint unsigned flen[64];
	int              fcount;
	longint unsigned a_user[64];
	longint unsigned a_span[64];
	longint unsigned a_pad[64];
	bit              a_valid[64];
	alloc_reply_t    replies[$];
	int              errors;

	function new();
		pool_sz     = 65536;
		search_best = 0;
		errors      = 0;
		reset_pool();
	endfunction

	function void reset_pool();
		fstart[0] = 0;
		if (pool_sz >= 16) begin
			flen[0] = pool_sz - 16;
			fcount  = 1;
		end else begin
			flen[0] = 0;
			fcount  = 0;
		end
		foreach (a_valid[i]) a_valid[i] = 0;
	endfunction

	function void write_reg(fla_pkg::cfg_reg_t idx, logic [19:0] val);
		if (idx == fla_pkg::REG_POOL_BYTES) pool_sz = val;
		else search_best = val[0];
	endfunction

	function int live_count();
		int n;
		n = 0;
		foreach (a_valid[i]) if (a_valid[i]) n++;
		return n;
	endfunction

	function logic [19:0] live_offset(int k);
		foreach (a_valid[i]) begin
			if (a_valid[i]) begin
				if (k == 0) return a_user[i][19:0];
				k--;
			end
		end
		return 0;
	endfunction

	function void push(fla_pkg::status_t st, longint unsigned off, longint unsigned pd);
		alloc_reply_t r;
		r.status = st;
		r.offset = off[19:0];
		r.pad    = pd[11:0];
		replies.push_back(r);
	endfunction

	function void allocate(longint unsigned size, longint unsigned al);
		longint unsigned waste, best_need, best_pad, p, need, tot, start, total, rem, split, user;
		int slot, pick;
		bit found;
		waste = 64'hFFFF_FFFF_FFFF_FFFF;
		best_need = 0;
		best_pad = 0;
		slot = -1;
		pick = 0;
		found = 0;
		if (size == 0) begin
			push(fla_pkg::STAT_ZERO, 0, 0);
			return;
		end
		if (al == 0) al = 16;
		if (al > 4096) al = 4096;
		for (int i = 0; i < 64; i++) if (!a_valid[i]) begin
			slot = i;
			break;
		end
		if (slot < 0) begin
			push(fla_pkg::STAT_FULL, 0, 0);
			return;
		end
		for (int i = 0; i < fcount; i++) begin
			p = ((fstart[i] + 16) % al) != 0 ? al - ((fstart[i] + 16) % al) : 0;
			need = p + 16 + size;
			tot = flen[i] + 16;
			if (tot >= need && tot - need < waste) begin
				waste = tot - need;
				best_need = need;
				best_pad = p;
				pick = i;
				found = 1;
				if (!search_best || waste == 0) break;
			end
		end
		if (!found) begin
			push(fla_pkg::STAT_NOFIT, 0, 0);
			return;
		end
		start = fstart[pick];
		total = flen[pick] + 16;
		rem = total - best_need;
		split = al > 16 ? al : 16;
		if (rem >= 16 + split) begin
			fstart[pick] = (start + best_need) & 20'hFFFFF;
			flen[pick] = (rem - 16) & 20'hFFFFF;
			a_span[slot] = best_need & 20'hFFFFF;
		end else begin
			for (int i = pick; i + 1 < fcount; i++) begin
				fstart[i] = fstart[i + 1];
				flen[i] = flen[i + 1];
			end
			fcount--;
			a_span[slot] = total & 20'hFFFFF;
		end
		user = (start + best_pad + 16) & 20'hFFFFF;
		a_user[slot] = user;
		a_pad[slot] = best_pad & 12'hFFF;
		a_valid[slot] = 1;
		push(fla_pkg::STAT_OK, user, best_pad);
	endfunction

	function void release_block(longint unsigned uoff);
		longint unsigned s, span, len;
		int slot, pos, n;
		bit jn, jp;
		slot = -1;
		n = fcount;
		for (int i = 0; i < 64; i++) if (a_valid[i] && a_user[i] == uoff) begin
			slot = i;
			break;
		end
		if (slot < 0) begin
			push(fla_pkg::STAT_UNKNOWN, 0, 0);
			return;
		end
		span = a_span[slot];
		s = (uoff - 16 - a_pad[slot]) & 20'hFFFFF;
		len = span >= 16 ? span - 16 : 0;
		pos = 0;
		while (pos < n && fstart[pos] < s) pos++;
		jn = pos < n && fstart[pos] == s + span;
		jp = pos > 0 && fstart[pos - 1] + flen[pos - 1] + 16 == s;
		if (!jn && !jp && n >= 64) begin
			push(fla_pkg::STAT_FULL, 0, 0);
			return;
		end
		if (jn) len += flen[pos] + 16;
		if (jp) begin
			flen[pos - 1] = (flen[pos - 1] + len + 16) & 20'hFFFFF;
			if (jn) begin
				for (int i = pos; i + 1 < n; i++) begin
					fstart[i] = fstart[i + 1];
					flen[i] = flen[i + 1];
				end
				fcount--;
			end
		end else if (jn) begin
			fstart[pos] = s;
			flen[pos] = len & 20'hFFFFF;
		end else begin
			for (int i = n; i > pos; i--) begin
				fstart[i] = fstart[i - 1];
				flen[i] = flen[i - 1];
			end
			fstart[pos] = s;
			flen[pos] = len & 20'hFFFFF;
			fcount++;
		end
		a_valid[slot] = 0;
		push(fla_pkg::STAT_OK, 0, 0);
	endfunction

	function void note_request(fla_pkg::mode_t m, logic [19:0] size, logic [12:0] al,
			logic [19:0] uoff);
		case (m)
			fla_pkg::MODE_ALLOC: allocate(size, al);
			fla_pkg::MODE_FREE: release_block(uoff);
			fla_pkg::MODE_POOL: begin
				reset_pool();
				push(fla_pkg::STAT_OK, 0, 0);
			end
			default: push(fla_pkg::STAT_OK, 0, 0);
		endcase
	endfunction

	function void check_reply(logic [39:0] data);
		alloc_reply_t r;
		if (replies.size() == 0) begin
			$error("unexpected result beat %h", data);
			errors++;
			return;
		end
		r = replies.pop_front();
		if (data[2:0] !== r.status) begin
			$error("status expected %0d actual %0d", r.status, data[2:0]);
			errors++;
		end
		if (data[22:3] !== r.offset) begin
			$error("result_offset expected %0h actual %0h", r.offset, data[22:3]);
			errors++;
		end
		if (data[34:23] !== r.pad) begin
			$error("padding_bytes expected %0d actual %0d", r.pad, data[34:23]);
			errors++;
		end
	endfunction
endclass

module tb_free_list_allocator_unit;
	import fla_pkg::*;

	localparam int IDLE_LIMIT = 20000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [55:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [39:0] m_tdata;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [0:0]  cfg_index = '0;
	logic [19:0] cfg_data = '0;

	alloc_scoreboard sb = new();
	bit calm = 0;
	int idle_cycles = 0;

	free_list_allocator_unit uut (.*);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (m_tvalid && m_tready) sb.check_reply(m_tdata);
		if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_free_list_allocator_unit: FAIL");
			$finish;
		end
	end

	function automatic int draw_gap();
		return calm ? 0 : $urandom_range(0, 18);
	endfunction

	initial begin
		int gap;
		forever begin
			gap = draw_gap();
			if (gap > 0) begin
				@(negedge clk) m_tready = 0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk) m_tready = 1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	task automatic send_request(mode_t m, logic [19:0] size, logic [12:0] al,
			logic [19:0] uoff);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			@(negedge clk) s_tvalid = 0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid = 1;
		s_tuser = m;
		s_tdata = {3'b000, uoff, al, size};
		do @(posedge clk); while (!s_tready);
		sb.note_request(m, size, al, uoff);
	endtask

	task automatic settle();
		@(negedge clk) s_tvalid = 0;
		while (sb.replies.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [19:0] val);
		@(negedge clk);
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
		@(negedge clk) cfg_valid = 0;
	endtask

	task automatic random_request(int alloc_weight);
		int r, n;
		logic [19:0] size;
		logic [12:0] al;
		r = $urandom_range(0, 99);
		n = sb.live_count();
		if (r < 3) begin
			send_request(MODE_POOL, 20'($urandom), 13'($urandom), 20'($urandom));
		end else if (r < 6) begin
			send_request(MODE_NOP, 20'($urandom), 13'($urandom), 20'($urandom));
		end else if (r < 10) begin
			send_request(MODE_FREE, 0, 0, 20'($urandom_range(0, 20'hFFFFF)));
		end else if (r < 10 + alloc_weight || n == 0) begin
			r = $urandom_range(0, 99);
			if (r < 4) size = 0;
			else if (r < 70) size = 20'($urandom_range(1, 200));
			else if (r < 90) size = 20'($urandom_range(1, sb.pool_sz / 8 + 1));
			else size = 20'($urandom_range(0, 20'hFFFFF));
			r = $urandom_range(0, 99);
			if (r < 30) al = 0;
			else if (r < 60) al = 13'd1 << $urandom_range(0, 12);
			else if (r < 85) al = 13'($urandom_range(1, 4096));
			else al = 13'($urandom_range(0, 8191));
			send_request(MODE_ALLOC, size, al, 20'($urandom));
		end else begin
			send_request(MODE_FREE, 20'($urandom), 13'($urandom),
				sb.live_offset($urandom_range(0, n - 1)));
		end
	endtask

	initial begin
		int pools[6] = '{65536, 1048575, 64, 4096, 300000, 8};
		int count;
		repeat (3) @(negedge clk);
		arst_n = 1;

		send_request(MODE_ALLOC, 0, 0, 0);
		send_request(MODE_ALLOC, 1, 0, 0);
		send_request(MODE_ALLOC, 40, 3, 0);
		send_request(MODE_ALLOC, 100, 4096, 0);
		send_request(MODE_ALLOC, 20, 8191, 0);
		send_request(MODE_ALLOC, 20, 4097, 0);
		send_request(MODE_ALLOC, 20'hFFFFF, 1, 0);
		send_request(MODE_FREE, 0, 0, 20'hFFFFF);
		send_request(MODE_NOP, 20'hFFFFF, 13'h1FFF, 20'hFFFFF);
		send_request(MODE_FREE, 0, 0, sb.live_offset(2));
		send_request(MODE_FREE, 0, 0, sb.live_offset(1));
		send_request(MODE_FREE, 0, 0, sb.live_offset(2));
		send_request(MODE_FREE, 0, 0, sb.live_offset(0));
		send_request(MODE_ALLOC, 65000, 1, 0);
		send_request(MODE_ALLOC, 16, 1, 0);
		send_request(MODE_POOL, 0, 0, 0);
		send_request(MODE_ALLOC, 65536 - 32, 1, 0);
		send_request(MODE_ALLOC, 1, 1, 0);
		settle();

		count = 0;
		for (int ph = 0; ph < 12; ph++) begin
			calm = (ph % 4 == 3);
			write_reg(REG_POOL_BYTES, 20'(pools[ph % 6]));
			write_reg(REG_SEARCH_MODE, 20'(ph[0]));
			send_request(MODE_POOL, 0, 0, 0);
			for (int k = 0; k < (pools[ph % 6] < 64 ? 8 : 60); k++)
				random_request(ph % 3 == 2 ? 75 : $urandom_range(40, 60));
			settle();
		end
		calm = 0;

		if (sb.errors == 0 && sb.replies.size() == 0) begin
			$display("tb_free_list_allocator_unit: PASS");
		end else begin
			$display("tb_free_list_allocator_unit: FAIL");
		end
		$finish;
	end
endmodule
